FILE: rtl/bss_pkg.sv
// Shared types and codes for the bounded set store with intersection.
// Holds the payload structs, action and status codes, the controller state
// and the per-cell command set. No dependencies.
package bss_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int ELEMENT_BITS_DEF = 32;

  // width of a fill count as carried to the cells and the results
  localparam int FILL_W = 7;

  localparam logic [2:0] ACT_APPEND_A  = 3'd0;
  localparam logic [2:0] ACT_APPEND_B  = 3'd1;
  localparam logic [2:0] ACT_REMOVE_A  = 3'd2;
  localparam logic [2:0] ACT_SIZE      = 3'd3;
  localparam logic [2:0] ACT_INTERSECT = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] item_value;
  } bss_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         count_a;
    logic               has_element;
    logic signed [31:0] element_out;
    logic               last;
  } bss_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_RIPPLE,
    S_SHIFT,
    S_SCAN,
    S_EMIT,
    S_FINAL
  } bss_state_t;

  typedef enum logic [3:0] {
    C_HOLD,
    C_APPEND_A,
    C_APPEND_B,
    C_MATCH,
    C_RIPPLE,
    C_SHIFT,
    C_INTER_INIT,
    C_SCAN_B,
    C_EMIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [FILL_W-1:0] fill_a;
    logic [FILL_W-1:0] fill_b;
  } cell_ctrl_t;

endpackage

FILE: rtl/bounded_set_store_with_intersection.sv
// Bounded set store with intersection: top level, a ring of Capacity cells
// driven by one sequencer. Depends on bss_pkg, bss_cell and bss_ctrl.
//
// Two stores, A and B, of up to Capacity elements each, held one entry per
// cell in a ring. Items are taken one at a time; the result sits in an
// output register, so the next item is taken while it waits. Append and
// size pass through the response state, which registers the result.
// Remove compares every filled entry against the value, carries the first
// match down the chain one cell a cycle, closes the gap, then responds.
// Intersect, which an output stall can hold, rotates B once through the
// ring while each cell marks its A entry, then rotates A once past the
// head cell, which emits the marked entries in order; the final member
// (or an empty marker) carries last.
// Stores need no clearing after reset.
module bounded_set_store_with_intersection #(
  parameter int Capacity    = bss_pkg::CAPACITY_DEF,
  parameter int ElementBits = bss_pkg::ELEMENT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bss_pkg::bss_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bss_pkg::bss_out_t out_data
);
  import bss_pkg::*;

  cell_ctrl_t             cell_ctrl;
  logic [ElementBits-1:0] key;
  logic [ElementBits-1:0] a_w [Capacity];
  logic [ElementBits-1:0] b_w [Capacity];
  logic                   bv_w [Capacity];
  logic                   hit_w [Capacity];
  logic                   p_w [Capacity];

  bss_ctrl #(
    .Capacity    (Capacity),
    .ElementBits (ElementBits)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head_a    (a_w[0]),
    .head_hit  (hit_w[0]),
    .found     (p_w[Capacity-1]),
    .cell_ctrl (cell_ctrl),
    .key       (key)
  );

  for (genvar i = 0; i < Capacity; i++) begin : g_chain
    localparam int Nxt = (i + 1) % Capacity;
    logic p_prev;

    if (i == 0) begin : g_head
      assign p_prev = 1'b0;
    end else begin : g_body
      assign p_prev = p_w[i-1];
    end

    bss_cell #(
      .ElementBits (ElementBits),
      .Index       (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .key      (key),
      .a_next   (a_w[Nxt]),
      .b_next   (b_w[Nxt]),
      .bv_next  (bv_w[Nxt]),
      .hit_next (hit_w[Nxt]),
      .p_prev   (p_prev),
      .a        (a_w[i]),
      .b        (b_w[i]),
      .bv       (bv_w[i]),
      .hit      (hit_w[i]),
      .p        (p_w[i])
    );
  end

  // a transfer in always moves the sequencer out of idle, so the input stalls after it
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.count_a <= 7'(Capacity))
    else $error("count of A beyond capacity");

  a_member_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_element |-> out_data.status == ST_OK)
    else $error("intersection member with non-ok status");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_element |-> out_data.element_out == '0 && out_data.last)
    else $error("result without member carries data or is not last");

endmodule

FILE: rtl/bss_cell.sv
// One cell of the store chain: holds entry Index of store A and of store B,
// plus match, prefix and validity flags. Depends on bss_pkg.
module bss_cell #(
  parameter int ElementBits = bss_pkg::ELEMENT_BITS_DEF,
  parameter int Index       = 0
) (
  input  logic                   clk,
  input  bss_pkg::cell_ctrl_t    ctrl,
  input  logic [ElementBits-1:0] key,
  input  logic [ElementBits-1:0] a_next,
  input  logic [ElementBits-1:0] b_next,
  input  logic                   bv_next,
  input  logic                   hit_next,
  input  logic                   p_prev,
  output logic [ElementBits-1:0] a,
  output logic [ElementBits-1:0] b,
  output logic                   bv,
  output logic                   hit,
  output logic                   p
);
  import bss_pkg::*;

  logic [ElementBits-1:0] a_r, a_nxt;
  logic [ElementBits-1:0] b_r, b_nxt;
  logic                   bv_r, bv_nxt;
  logic                   hit_r, hit_nxt;
  logic                   p_r, p_nxt;
  logic                   in_a, in_b;

  assign in_a = FILL_W'(Index) < ctrl.fill_a;
  assign in_b = FILL_W'(Index) < ctrl.fill_b;

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    bv_nxt  = bv_r;
    hit_nxt = hit_r;
    p_nxt   = p_r;
    case (ctrl.op)
      C_APPEND_A: begin
        if (FILL_W'(Index) == ctrl.fill_a) a_nxt = key;
      end
      C_APPEND_B: begin
        if (FILL_W'(Index) == ctrl.fill_b) b_nxt = key;
      end
      C_MATCH:  p_nxt = in_a && (a_r == key);
      // spread the first match towards the tail, one cell a cycle
      C_RIPPLE: p_nxt = p_r | p_prev;
      C_SHIFT: begin
        if (p_r) a_nxt = a_next;
      end
      C_INTER_INIT: begin
        bv_nxt  = in_b;
        hit_nxt = 1'b0;
      end
      // rotate B past the resting A entries, marking each A entry that matches
      C_SCAN_B: begin
        b_nxt  = b_next;
        bv_nxt = bv_next;
        if (in_a && bv_r && (a_r == b_r)) hit_nxt = 1'b1;
      end
      // rotate A and its hit flag towards the head
      C_EMIT: begin
        a_nxt   = a_next;
        hit_nxt = hit_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    bv_r  <= bv_nxt;
    hit_r <= hit_nxt;
    p_r   <= p_nxt;
  end

  assign a   = a_r;
  assign b   = b_r;
  assign bv  = bv_r;
  assign hit = hit_r;
  assign p   = p_r;

endmodule

FILE: rtl/bss_ctrl.sv
// Sequencer for the store chain: fill counts, command issue, result
// register and the one-deep lookahead for intersection members.
// Depends on bss_pkg.
module bss_ctrl #(
  parameter int Capacity    = bss_pkg::CAPACITY_DEF,
  parameter int ElementBits = bss_pkg::ELEMENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bss_pkg::bss_in_t       in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bss_pkg::bss_out_t      out_data,
  input  logic [ElementBits-1:0] head_a,
  input  logic                   head_hit,
  input  logic                   found,
  output bss_pkg::cell_ctrl_t    cell_ctrl,
  output logic [ElementBits-1:0] key
);
  import bss_pkg::*;

  localparam int FillW = $clog2(Capacity + 1);
  localparam int CntW  = $clog2(Capacity);
  localparam logic [FillW-1:0] FullCount     = FillW'(Capacity);
  localparam logic [CntW-1:0]  CntLastScan   = CntW'(Capacity - 1);
  localparam logic [CntW-1:0]  CntLastRipple = CntW'(Capacity - 2);

  bss_state_t             state_r, state_nxt;
  logic [FillW-1:0]       fill_a_r, fill_a_nxt;
  logic [FillW-1:0]       fill_b_r, fill_b_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [ElementBits-1:0] pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bss_out_t               out_r, out_nxt;
  logic                   push;
  bss_out_t               push_data;
  cell_op_t               op;
  logic                   can_push;
  logic                   advance;

  assign can_push = !out_valid_r || !out_stall;
  // hold the rotation while a displaced member cannot be passed on
  assign advance  = !(head_hit && pend_v_r) || can_push;
  assign key      = ElementBits'(in_data.item_value);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.action)
            ACT_REMOVE_A:  state_nxt = (fill_a_r == '0) ? S_RESP : S_RIPPLE;
            ACT_INTERSECT: state_nxt = S_SCAN;
            default:       state_nxt = S_RESP;
          endcase
        end
      end
      S_RESP:   if (can_push) state_nxt = S_IDLE;
      S_RIPPLE: if (cnt_r == CntLastRipple) state_nxt = S_SHIFT;
      S_SHIFT:  state_nxt = S_RESP;
      S_SCAN:   if (cnt_r == CntLastScan) state_nxt = S_EMIT;
      S_EMIT:   if (advance && (cnt_r == CntLastScan)) state_nxt = S_FINAL;
      S_FINAL:  if (can_push) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fill_a_nxt  = fill_a_r;
    fill_b_nxt  = fill_b_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    op          = C_HOLD;
    push        = 1'b0;
    push_data   = '0;
    push_data.count_a = 7'(fill_a_r);
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          case (in_data.action)
            ACT_APPEND_A: begin
              if (fill_a_r == FullCount) begin
                status_nxt = ST_FULL;
              end else begin
                op         = C_APPEND_A;
                fill_a_nxt = fill_a_r + 1'b1;
                status_nxt = ST_OK;
              end
            end
            ACT_APPEND_B: begin
              if (fill_b_r == FullCount) begin
                status_nxt = ST_FULL;
              end else begin
                op         = C_APPEND_B;
                fill_b_nxt = fill_b_r + 1'b1;
                status_nxt = ST_OK;
              end
            end
            ACT_REMOVE_A: begin
              if (fill_a_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                op = C_MATCH;
              end
            end
            ACT_INTERSECT: begin
              op         = C_INTER_INIT;
              pend_v_nxt = 1'b0;
            end
            ACT_SIZE: status_nxt = ST_OK;
            default:  status_nxt = ST_OK;
          endcase
        end
      end
      S_RESP: begin
        if (can_push) begin
          push             = 1'b1;
          push_data.status = status_r;
          push_data.last   = 1'b1;
        end
      end
      S_RIPPLE: begin
        op      = C_RIPPLE;
        cnt_nxt = cnt_r + 1'b1;
      end
      S_SHIFT: begin
        if (found) begin
          op         = C_SHIFT;
          fill_a_nxt = fill_a_r - 1'b1;
          status_nxt = ST_OK;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      S_SCAN: begin
        op      = C_SCAN_B;
        cnt_nxt = (cnt_r == CntLastScan) ? '0 : cnt_r + 1'b1;
      end
      S_EMIT: begin
        if (advance) begin
          op      = C_EMIT;
          cnt_nxt = cnt_r + 1'b1;
          if (head_hit) begin
            if (pend_v_r) begin
              push                  = 1'b1;
              push_data.status      = ST_OK;
              push_data.has_element = 1'b1;
              push_data.element_out = 32'($signed(pend_r));
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = head_a;
          end
        end
      end
      S_FINAL: begin
        if (can_push) begin
          push                  = 1'b1;
          push_data.status      = ST_OK;
          push_data.has_element = pend_v_r;
          push_data.element_out = pend_v_r ? 32'($signed(pend_r)) : '0;
          push_data.last        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = push ? 1'b1 : (out_valid_r && out_stall);
    out_nxt       = push ? push_data : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_a_r    <= '0;
      fill_b_r    <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_a_r    <= fill_a_nxt;
      fill_b_r    <= fill_b_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;
  assign cell_ctrl.op     = op;
  assign cell_ctrl.fill_a = FILL_W'(fill_a_r);
  assign cell_ctrl.fill_b = FILL_W'(fill_b_r);

endmodule
